FILE: rtl/core/vsaw_pkg.sv
package vsaw_pkg;

    localparam int AXIS_BITS   = 12;
    localparam int STEP_BITS   = 8;
    localparam int ORIGIN_BITS = 16;
    localparam int COORD_BITS  = 24;
    localparam int ADDR_BITS   = 3 * AXIS_BITS;
    localparam int DIM_BITS    = AXIS_BITS + 1;
    localparam int PROD_BITS   = AXIS_BITS + DIM_BITS;
    localparam int ROWA_BITS   = PROD_BITS + 1;
    localparam int PLANE_BITS  = PROD_BITS + DIM_BITS;

    localparam int STEPS_BITS  = 3 * STEP_BITS;
    localparam int VOL_BITS    = 3 * AXIS_BITS;
    localparam int SLICE_BITS  = 2 * AXIS_BITS;

    localparam int CFG_BITS_A  = (VOL_BITS > STEPS_BITS) ? VOL_BITS : STEPS_BITS;
    localparam int CFG_BITS_B  = (SLICE_BITS > ORIGIN_BITS) ? SLICE_BITS : ORIGIN_BITS;
    localparam int CFG_BITS    = (CFG_BITS_A > CFG_BITS_B) ? CFG_BITS_A : CFG_BITS_B;
    localparam int CFG_IDX_BITS = 3;

    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = ((ADDR_BITS + 2 * AXIS_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ORIGIN_I    = 3'd0,
        REG_ORIGIN_J    = 3'd1,
        REG_ORIGIN_K    = 3'd2,
        REG_COL_STEP    = 3'd3,
        REG_ROW_STEP    = 3'd4,
        REG_VOLUME_LAST = 3'd5,
        REG_SLICE_LAST  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [ORIGIN_BITS-1:0] origin_i;
        logic [ORIGIN_BITS-1:0] origin_j;
        logic [ORIGIN_BITS-1:0] origin_k;
        logic [STEPS_BITS-1:0]  col_step;
        logic [STEPS_BITS-1:0]  row_step;
        logic [VOL_BITS-1:0]    volume_last;
        logic [SLICE_BITS-1:0]  slice_last;
    } cfg_t;

    // coordinates are zeroed when outside, so the address comes out as 0
    typedef struct packed {
        logic [AXIS_BITS-1:0] ci;
        logic [AXIS_BITS-1:0] cj;
        logic [AXIS_BITS-1:0] ck;
        logic                 in_vol;
        logic [AXIS_BITS-1:0] col;
        logic [AXIS_BITS-1:0] row;
        logic                 row_end;
        logic                 slice_end;
    } pix_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic                 in_vol;
        logic [AXIS_BITS-1:0] col;
        logic [AXIS_BITS-1:0] row;
        logic                 row_end;
        logic                 slice_end;
    } res_t;

    function automatic logic [COORD_BITS-1:0] step_ext(input logic [STEP_BITS-1:0] s);
        step_ext = {{(COORD_BITS-STEP_BITS){s[STEP_BITS-1]}}, s};
    endfunction

    function automatic logic [COORD_BITS-1:0] origin_ext(input logic [ORIGIN_BITS-1:0] o);
        origin_ext = {{(COORD_BITS-ORIGIN_BITS){o[ORIGIN_BITS-1]}}, o};
    endfunction

endpackage

FILE: rtl/core/vsaw_cfg.sv
module vsaw_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [vsaw_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [vsaw_pkg::CFG_BITS-1:0]  cfg_wdata,
    output vsaw_pkg::cfg_t                 cfg
);
    import vsaw_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ORIGIN_I:    cfg_next.origin_i    = cfg_wdata[ORIGIN_BITS-1:0];
                REG_ORIGIN_J:    cfg_next.origin_j    = cfg_wdata[ORIGIN_BITS-1:0];
                REG_ORIGIN_K:    cfg_next.origin_k    = cfg_wdata[ORIGIN_BITS-1:0];
                REG_COL_STEP:    cfg_next.col_step    = cfg_wdata[STEPS_BITS-1:0];
                REG_ROW_STEP:    cfg_next.row_step    = cfg_wdata[STEPS_BITS-1:0];
                REG_VOLUME_LAST: cfg_next.volume_last = cfg_wdata[VOL_BITS-1:0];
                REG_SLICE_LAST:  cfg_next.slice_last  = cfg_wdata[SLICE_BITS-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/vsaw_walker.sv
module vsaw_walker (
    input  logic           clk,
    input  logic           rst_n,
    input  vsaw_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           restart,
    output logic           pix_valid,
    input  logic           pix_ready,
    output vsaw_pkg::pix_t pix
);
    import vsaw_pkg::*;

    logic [COORD_BITS-1:0] cur_i_reg, cur_j_reg, cur_k_reg;
    logic [COORD_BITS-1:0] cur_i_next, cur_j_next, cur_k_next;
    logic [COORD_BITS-1:0] rs_i_reg, rs_j_reg, rs_k_reg;
    logic [COORD_BITS-1:0] rs_i_next, rs_j_next, rs_k_next;
    logic [AXIS_BITS-1:0]  col_reg, row_reg, col_next, row_next;
    logic                  vld_reg, vld_next;
    pix_t                  pix_reg, pix_next;

    logic [COORD_BITS-1:0] org_i, org_j, org_k;
    logic [COORD_BITS-1:0] b_i, b_j, b_k, br_i, br_j, br_k;
    logic [COORD_BITS-1:0] nr_i, nr_j, nr_k;
    logic [AXIS_BITS-1:0]  b_col, b_row;
    logic                  in_vol, rend, send, accept;

    assign in_ready = !vld_reg || pix_ready;
    assign accept   = in_valid && in_ready;

    assign org_i = origin_ext(cfg.origin_i);
    assign org_j = origin_ext(cfg.origin_j);
    assign org_k = origin_ext(cfg.origin_k);

    always_comb
    begin
        b_i   = restart ? org_i : cur_i_reg;
        b_j   = restart ? org_j : cur_j_reg;
        b_k   = restart ? org_k : cur_k_reg;
        br_i  = restart ? org_i : rs_i_reg;
        br_j  = restart ? org_j : rs_j_reg;
        br_k  = restart ? org_k : rs_k_reg;
        b_col = restart ? '0 : col_reg;
        b_row = restart ? '0 : row_reg;

        in_vol = !b_i[COORD_BITS-1] && !b_j[COORD_BITS-1] && !b_k[COORD_BITS-1]
              && (b_i <= COORD_BITS'(cfg.volume_last[AXIS_BITS-1:0]))
              && (b_j <= COORD_BITS'(cfg.volume_last[2*AXIS_BITS-1:AXIS_BITS]))
              && (b_k <= COORD_BITS'(cfg.volume_last[3*AXIS_BITS-1:2*AXIS_BITS]));
        rend = b_col >= cfg.slice_last[AXIS_BITS-1:0];
        send = rend && (b_row >= cfg.slice_last[2*AXIS_BITS-1:AXIS_BITS]);

        nr_i = br_i + step_ext(cfg.row_step[STEP_BITS-1:0]);
        nr_j = br_j + step_ext(cfg.row_step[2*STEP_BITS-1:STEP_BITS]);
        nr_k = br_k + step_ext(cfg.row_step[3*STEP_BITS-1:2*STEP_BITS]);

        pix_next.ci        = in_vol ? b_i[AXIS_BITS-1:0] : '0;
        pix_next.cj        = in_vol ? b_j[AXIS_BITS-1:0] : '0;
        pix_next.ck        = in_vol ? b_k[AXIS_BITS-1:0] : '0;
        pix_next.in_vol    = in_vol;
        pix_next.col       = b_col;
        pix_next.row       = b_row;
        pix_next.row_end   = rend;
        pix_next.slice_end = send;

        if (send)
        begin
            cur_i_next = org_i;
            cur_j_next = org_j;
            cur_k_next = org_k;
            rs_i_next  = org_i;
            rs_j_next  = org_j;
            rs_k_next  = org_k;
            col_next   = '0;
            row_next   = '0;
        end
        else if (rend)
        begin
            cur_i_next = nr_i;
            cur_j_next = nr_j;
            cur_k_next = nr_k;
            rs_i_next  = nr_i;
            rs_j_next  = nr_j;
            rs_k_next  = nr_k;
            col_next   = '0;
            row_next   = b_row + AXIS_BITS'(1);
        end
        else
        begin
            cur_i_next = b_i + step_ext(cfg.col_step[STEP_BITS-1:0]);
            cur_j_next = b_j + step_ext(cfg.col_step[2*STEP_BITS-1:STEP_BITS]);
            cur_k_next = b_k + step_ext(cfg.col_step[3*STEP_BITS-1:2*STEP_BITS]);
            rs_i_next  = br_i;
            rs_j_next  = br_j;
            rs_k_next  = br_k;
            col_next   = b_col + AXIS_BITS'(1);
            row_next   = b_row;
        end

        vld_next = accept ? 1'b1 : (pix_ready ? 1'b0 : vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_i_reg <= '0;
            cur_j_reg <= '0;
            cur_k_reg <= '0;
            rs_i_reg  <= '0;
            rs_j_reg  <= '0;
            rs_k_reg  <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (accept)
            begin
                cur_i_reg <= cur_i_next;
                cur_j_reg <= cur_j_next;
                cur_k_reg <= cur_k_next;
                rs_i_reg  <= rs_i_next;
                rs_j_reg  <= rs_j_next;
                rs_k_reg  <= rs_k_next;
                col_reg   <= col_next;
                row_reg   <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= pix_next;
    end

    assign pix_valid = vld_reg;
    assign pix       = pix_reg;

endmodule

FILE: rtl/core/vsaw_addr.sv
module vsaw_addr (
    input  logic           clk,
    input  logic           rst_n,
    input  vsaw_pkg::cfg_t cfg,
    input  logic           pix_valid,
    output logic           pix_ready,
    input  vsaw_pkg::pix_t pix,
    output logic           res_valid,
    input  logic           res_ready,
    output vsaw_pkg::res_t res
);
    import vsaw_pkg::*;

    typedef struct packed {
        logic [PROD_BITS-1:0] kn;
        logic [ROWA_BITS-1:0] jn;
        pix_t                 p;
    } s1_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] plane;
        logic [ROWA_BITS-1:0] jn;
        pix_t                 p;
    } s2_t;

    logic [DIM_BITS-1:0]   ni, nj;
    logic [PLANE_BITS-1:0] plane_full;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    res_t res_reg, res_next;
    logic s1_vld_reg, s2_vld_reg, o_vld_reg;
    logic s1_rdy, s2_rdy, o_rdy;

    assign ni = DIM_BITS'(cfg.volume_last[AXIS_BITS-1:0]) + DIM_BITS'(1);
    assign nj = DIM_BITS'(cfg.volume_last[2*AXIS_BITS-1:AXIS_BITS]) + DIM_BITS'(1);

    assign o_rdy     = !o_vld_reg || res_ready;
    assign s2_rdy    = !s2_vld_reg || o_rdy;
    assign s1_rdy    = !s1_vld_reg || s2_rdy;
    assign pix_ready = s1_rdy;

    always_comb
    begin
        s1_next.kn = PROD_BITS'(pix.ck) * PROD_BITS'(ni);
        s1_next.jn = ROWA_BITS'(PROD_BITS'(pix.cj) * PROD_BITS'(ni))
                   + ROWA_BITS'(pix.ci);
        s1_next.p  = pix;

        plane_full     = PLANE_BITS'(s1_reg.kn) * PLANE_BITS'(nj);
        s2_next.plane  = plane_full[ADDR_BITS-1:0];
        s2_next.jn     = s1_reg.jn;
        s2_next.p      = s1_reg.p;

        res_next.addr      = s2_reg.plane + ADDR_BITS'(s2_reg.jn);
        res_next.in_vol    = s2_reg.p.in_vol;
        res_next.col       = s2_reg.p.col;
        res_next.row       = s2_reg.p.row;
        res_next.row_end   = s2_reg.p.row_end;
        res_next.slice_end = s2_reg.p.slice_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
                s1_vld_reg <= pix_valid;
            if (s2_rdy)
                s2_vld_reg <= s1_vld_reg;
            if (o_rdy)
                o_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy && pix_valid)
            s1_reg <= s1_next;
        if (s2_rdy && s1_vld_reg)
            s2_reg <= s2_next;
        if (o_rdy && s2_vld_reg)
            res_reg <= res_next;
    end

    assign res_valid = o_vld_reg;
    assign res       = res_reg;

endmodule

FILE: rtl/core/volume_slice_address_walker.sv
// m_tvalid follows an accepted request through the walker register, two multiply stages
// and the output register.
// One request per cycle unless m_tready stalls; the walk's add/compare loop is combinational.
// Stalls fill pipeline bubbles first, so s_tready drops only when every stage holds data.
// Reset (rst_n, async, active low): config registers zero, walk at origin 0, pipeline empty.
module volume_slice_address_walker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [vsaw_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [vsaw_pkg::CFG_BITS-1:0]        cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [vsaw_pkg::IN_TDATA_BITS-1:0]   s_tdata,  // restart
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [vsaw_pkg::OUT_TDATA_BITS-1:0]  m_tdata,  // voxel_address, out_col, out_row
    output logic [vsaw_pkg::OUT_TUSER_BITS-1:0]  m_tuser,  // inside_res, row_end
    output logic                                 m_tlast   // slice_end
);
    import vsaw_pkg::*;

    cfg_t cfg;
    pix_t pix;
    res_t res;
    logic pix_valid, pix_ready;

    vsaw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vsaw_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .restart   (s_tdata[0]),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    vsaw_addr u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = OUT_TDATA_BITS'({res.row, res.col, res.addr});
    assign m_tuser = {res.row_end, res.in_vol};
    assign m_tlast = res.slice_end;

    a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("slice end without row end");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[ADDR_BITS-1:0] == '0)
        else $error("outside voxel with nonzero address");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output side free");

endmodule
